### rtl/core/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared constants, operation codes and types for the flow hash steering block.
// ----------------------------------------------------------------------------
package sfh_pkg;

  localparam int unsigned MAX_WORKERS_DEF = 64;

  localparam logic [31:0] MIX_MULT      = 32'h045d9f3b;
  localparam int unsigned MIN_FRAME_LEN = 38;
  localparam logic [7:0]  TYPE_IPV4     = 8'h08;
  localparam logic [7:0]  TYPE_VLAN     = 8'h81;
  localparam logic [4:0]  OFFSET_IPV4   = 5'd26;
  localparam logic [4:0]  OFFSET_VLAN   = 5'd30;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  localparam int unsigned MIX_PASSES = 2;
  localparam int unsigned DIV_STEPS  = 32;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_MIX  = 2'd0;
  localparam alu_op_t OP_FOLD = 2'd1;
  localparam alu_op_t OP_REM  = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic        ok;
  } frame_sum_t;

endpackage

### rtl/core/sfh_capture.sv
// ----------------------------------------------------------------------------
// sfh_capture
// Byte parser: tracks frame position, picks the IPv4 header offset from the
// type bytes and captures protocol, addresses and ports.
// ----------------------------------------------------------------------------
module sfh_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output sfh_pkg::frame_sum_t sum
);

  localparam logic [5:0] POS_TYPE_HI = 6'd12;
  localparam logic [5:0] POS_TYPE_LO = 6'd13;
  localparam logic [5:0] POS_MAX     = 6'd63;

  logic [5:0]  pos_r,   pos_nxt;
  logic [7:0]  type_r,  type_nxt;
  logic [4:0]  off_r,   off_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r,   src_nxt;
  logic [31:0] dst_r,   dst_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [5:0]  off_ext;
  logic [5:0]  d;
  logic [15:0] ports;

  always_comb begin
    type_nxt  = type_r;
    off_nxt   = off_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 6'd1;

    if (pos_r == POS_TYPE_HI) begin
      type_nxt = data_byte;
    end
    if (pos_r == POS_TYPE_LO) begin
      if (data_byte == 8'd0 && type_r == sfh_pkg::TYPE_IPV4) begin
        off_nxt = sfh_pkg::OFFSET_IPV4;
      end else if (data_byte == 8'd0 && type_r == sfh_pkg::TYPE_VLAN) begin
        off_nxt = sfh_pkg::OFFSET_VLAN;
      end else begin
        off_nxt = 5'd0;
      end
    end

    off_ext = {1'b0, off_nxt};
    d       = pos_r - off_ext;

    if (off_nxt != 5'd0) begin
      if (pos_r == off_ext - 6'd3) begin
        proto_nxt = data_byte;
      end
      if (pos_r >= off_ext) begin
        case (d)
          6'd0:  src_nxt[7:0]     = data_byte;
          6'd1:  src_nxt[15:8]    = data_byte;
          6'd2:  src_nxt[23:16]   = data_byte;
          6'd3:  src_nxt[31:24]   = data_byte;
          6'd4:  dst_nxt[7:0]     = data_byte;
          6'd5:  dst_nxt[15:8]    = data_byte;
          6'd6:  dst_nxt[23:16]   = data_byte;
          6'd7:  dst_nxt[31:24]   = data_byte;
          6'd8:  sport_nxt[7:0]   = data_byte;
          6'd9:  sport_nxt[15:8]  = data_byte;
          6'd10: dport_nxt[7:0]   = data_byte;
          6'd11: dport_nxt[15:8]  = data_byte;
          default: ;
        endcase
      end
    end

    if (proto_nxt == sfh_pkg::PROTO_TCP || proto_nxt == sfh_pkg::PROTO_UDP) begin
      ports = sport_nxt | dport_nxt;
    end else begin
      ports = 16'd0;
    end

    sum.key = src_nxt | dst_nxt | {16'd0, ports};
    sum.ok  = (pos_r >= 6'(sfh_pkg::MIN_FRAME_LEN - 1)) && (off_nxt != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r   <= 6'd0;
      type_r  <= 8'd0;
      off_r   <= 5'd0;
      proto_r <= 8'd0;
      src_r   <= 32'd0;
      dst_r   <= 32'd0;
      sport_r <= 16'd0;
      dport_r <= 16'd0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      off_r   <= off_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

endmodule

### rtl/core/sfh_alu.sv
// ----------------------------------------------------------------------------
// sfh_alu
// Shared datapath: fold-and-multiply mixing round, final fold, and one
// restoring remainder step.
// ----------------------------------------------------------------------------
module sfh_alu #(
  parameter int unsigned DIV_W = 7
) (
  input  sfh_pkg::alu_op_t   op,
  input  logic [31:0]        a,
  input  logic [DIV_W-1:0]   rem,
  input  logic [DIV_W-1:0]   divisor,
  output logic [31:0]        y,
  output logic [DIV_W-1:0]   rem_o
);

  logic [31:0]    fold;
  logic [DIV_W:0] trial;

  always_comb begin
    fold  = a ^ (a >> 16);
    trial = {rem, a[31]};
    y     = a;
    rem_o = rem;
    case (op)
      sfh_pkg::OP_MIX: begin
        y = fold * sfh_pkg::MIX_MULT;
      end
      sfh_pkg::OP_FOLD: begin
        y = fold;
      end
      sfh_pkg::OP_REM: begin
        y = a << 1;
        if (trial >= {1'b0, divisor}) begin
          rem_o = DIV_W'(trial - {1'b0, divisor});
        end else begin
          rem_o = trial[DIV_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/sfh_seq.sv
// ----------------------------------------------------------------------------
// sfh_seq
// Sequencer around the shared datapath: two mixing rounds, a fold, then a
// bit-serial remainder, and the result register.
// ----------------------------------------------------------------------------
module sfh_seq #(
  parameter int unsigned DIV_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sfh_pkg::frame_sum_t sum,
  input  logic [DIV_W-1:0]   divisor,
  input  logic               out_stall,
  output logic               busy,
  output logic               out_valid,
  output logic [31:0]        out_flow_hash,
  output logic [5:0]         out_worker_index,
  output logic               out_classified
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIX  = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  localparam int unsigned EXT_W = (DIV_W > 6) ? DIV_W : 6;
  localparam logic [4:0] MIX_LAST = 5'(sfh_pkg::MIX_PASSES - 1);
  localparam logic [4:0] DIV_LAST = 5'(sfh_pkg::DIV_STEPS - 1);

  logic [2:0]       state_r;
  logic [4:0]       cnt_r;
  logic [31:0]      acc_r;
  logic [31:0]      hash_r;
  logic [DIV_W-1:0] rem_r;
  logic             ok_r;
  logic             out_valid_r;
  logic [31:0]      out_hash_r;
  logic [5:0]       out_idx_r;
  logic             out_cls_r;

  sfh_pkg::alu_op_t alu_op;
  logic [31:0]      alu_y;
  logic [DIV_W-1:0] alu_rem;
  logic             out_free;
  logic             out_load;
  logic [EXT_W-1:0] rem_ext;
  logic [EXT_W-1:0] hold_ext;

  always_comb begin
    case (state_r)
      S_MIX:   alu_op = sfh_pkg::OP_MIX;
      S_DIV:   alu_op = sfh_pkg::OP_REM;
      default: alu_op = sfh_pkg::OP_FOLD;
    endcase
  end

  sfh_alu #(.DIV_W(DIV_W)) u_alu (
    .op      (alu_op),
    .a       (acc_r),
    .rem     (rem_r),
    .divisor (divisor),
    .y       (alu_y),
    .rem_o   (alu_rem)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free &&
                    ((state_r == S_HOLD) || ((state_r == S_DIV) && (cnt_r == DIV_LAST)));
  assign rem_ext  = EXT_W'(alu_rem);
  assign hold_ext = EXT_W'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            acc_r   <= sum.ok ? sum.key : 32'd0;
            ok_r    <= sum.ok;
            cnt_r   <= 5'd0;
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          acc_r <= alu_y;
          if (cnt_r == MIX_LAST) begin
            cnt_r   <= 5'd0;
            state_r <= S_FOLD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_FOLD: begin
          acc_r   <= alu_y;
          hash_r  <= alu_y;
          rem_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          acc_r <= alu_y;
          rem_r <= alu_rem;
          if (cnt_r == DIV_LAST) begin
            cnt_r <= 5'd0;
            if (out_free) begin
              out_hash_r  <= hash_r;
              out_idx_r   <= rem_ext[5:0];
              out_cls_r   <= ok_r;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_hash_r  <= hash_r;
            out_idx_r   <= hold_ext[5:0];
            out_cls_r   <= ok_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_flow_hash    = out_hash_r;
  assign out_worker_index = out_idx_r;
  assign out_classified   = out_cls_r;

endmodule

### rtl/core/symmetric_flow_hash_steering.sv
// Throughput: one byte per cycle within a frame; the last byte holds the
// input stalled while the shared datapath runs two multiply rounds, a fold
// and a 32-step bit-serial remainder, and further while out_stall still
// holds the previous result.
// Reset: synchronous active-low; clears frame state, worker_count to 1.
// ----------------------------------------------------------------------------
// symmetric_flow_hash_steering
// Parses Ethernet frames byte by byte, forms a symmetric flow hash over the
// IPv4 addresses and TCP/UDP ports and picks a worker by hash modulo count.
// ----------------------------------------------------------------------------
module symmetric_flow_hash_steering #(
  parameter int unsigned MAX_WORKERS = sfh_pkg::MAX_WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_flow_hash,
  output logic [5:0]  out_worker_index,
  output logic        out_classified
);

  localparam int unsigned DIV_W = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CMP_W = (DIV_W > 7) ? DIV_W : 7;
  localparam int unsigned EXT_W = (DIV_W > 6) ? DIV_W : 6;

  logic [6:0]       worker_count_r;
  logic [CMP_W-1:0] count_ext;
  logic [DIV_W-1:0] div_eff;
  logic             in_accept;
  logic             busy;
  sfh_pkg::frame_sum_t sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= 7'd1;
    end else if (cfg_wr_en) begin
      worker_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    count_ext = CMP_W'(worker_count_r);
    if (count_ext == '0) begin
      div_eff = DIV_W'(1);
    end else if (count_ext > CMP_W'(MAX_WORKERS)) begin
      div_eff = DIV_W'(MAX_WORKERS);
    end else begin
      div_eff = DIV_W'(count_ext);
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  sfh_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .sum       (sum)
  );

  sfh_seq #(.DIV_W(DIV_W)) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (in_accept && in_last_byte),
    .sum              (sum),
    .divisor          (div_eff),
    .out_stall        (out_stall),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_flow_hash    (out_flow_hash),
    .out_worker_index (out_worker_index),
    .out_classified   (out_classified)
  );

`ifndef NO_ASSERTIONS
  a_unclassified_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_classified |-> out_flow_hash == 32'd0 && out_worker_index == 6'd0)
    else $error("unclassified request with nonzero hash or index");

  a_last_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> in_stall)
    else $error("input not stalled after last byte");

  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> EXT_W'(out_worker_index) < EXT_W'(div_eff))
    else $error("worker index not below worker count");
`endif

endmodule
